/* design/dtsp_pkg.sv */
// Shared types and constants for the date-time text parser.
// Used by the interfaces, the front classifier, the token queue, the back end and the top level.
package dtsp_pkg;

	localparam int CHAR_W      = 8;
	localparam int ACC_W       = 16;
	localparam int FIELD_W     = 8;
	localparam int FIELD_COUNT = 6;
	localparam int IDX_W       = 3;
	localparam int STATUS_W    = 2;

	localparam logic [ACC_W-1:0]  NO_VALUE  = 16'hFFFF;
	localparam logic [ACC_W-1:0]  YEAR_BASE = 16'd2000;
	localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
	localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;

	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);
	localparam int QCW    = $clog2(QDEPTH + 1);

	typedef enum logic [1:0] {
		TOK_DIGIT,
		TOK_SEP,
		TOK_MINUS,
		TOK_END
	} dtsp_kind_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_PAST   = 2'd0,
		ST_FUTURE = 2'd1,
		ST_FULL   = 2'd2
	} dtsp_status_t;

	typedef struct packed {
		dtsp_kind_t  kind;
		logic [3:0]  digit;
	} dtsp_token_t;

	typedef struct packed {
		logic        valid;
		dtsp_token_t tok;
	} dtsp_qhead_t;

endpackage

/* design/dtsp_char_if.sv */
// Character request channel: valid/ready handshake carrying one text character.
// Depends on dtsp_pkg.
interface dtsp_char_if;
	logic                         valid;
	logic                         ready;
	logic [dtsp_pkg::CHAR_W-1:0]  char_code;

	modport source (output valid, output char_code, input ready);
	modport sink   (input valid, input char_code, output ready);
endinterface

/* design/dtsp_result_if.sv */
// Result request channel: valid/ready handshake carrying status and parsed fields.
// Depends on dtsp_pkg.
interface dtsp_result_if;
	logic                           valid;
	logic                           ready;
	logic [dtsp_pkg::STATUS_W-1:0]  status;
	logic [dtsp_pkg::FIELD_W-1:0]   year;
	logic [dtsp_pkg::FIELD_W-1:0]   month;
	logic [dtsp_pkg::FIELD_W-1:0]   day;
	logic [dtsp_pkg::FIELD_W-1:0]   hours;
	logic [dtsp_pkg::FIELD_W-1:0]   minutes;
	logic [dtsp_pkg::FIELD_W-1:0]   seconds;
	logic [dtsp_pkg::IDX_W-1:0]     fields_found;

	modport source (output valid, output status, output year, output month, output day,
		output hours, output minutes, output seconds, output fields_found, input ready);
	modport sink   (input valid, input status, input year, input month, input day,
		input hours, input minutes, input seconds, input fields_found, output ready);
endinterface

/* design/datetime_string_parser.sv */
// Top level of the date-time text parser: front classifier, token queue, back end.
// Depends on dtsp_pkg, dtsp_char_if, dtsp_result_if, dtsp_front, dtsp_queue, dtsp_back.
//
//   port     dir   payload                                          request
//   chars    sink  char_code[7:0]                                   one character
//   results  src   status, year..seconds, fields_found              one parsed string
//
// One character is taken per cycle while the token queue is not full; the
// accumulator multiply-add and field store in the back end are combinational.
// With the queue empty, a terminator is first written into the token queue and
// its result is then registered in the back end's result register.
// A held result stalls the back end only at the next terminator; the four-entry
// token queue keeps taking characters meanwhile until it is full.
// Reset clears control state; field storage is cleared at the start of each string.
module datetime_string_parser (
	input  logic          clk,
	input  logic          arst_n,
	dtsp_char_if.sink     chars,
	dtsp_result_if.source results
);

	logic                   push;
	logic                   pop;
	logic                   q_full;
	dtsp_pkg::dtsp_token_t  push_tok;
	dtsp_pkg::dtsp_qhead_t  head;

	dtsp_front u_front (
		.chars  (chars),
		.q_full (q_full),
		.push   (push),
		.tok    (push_tok)
	);

	dtsp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_tok (push_tok),
		.pop      (pop),
		.full     (q_full),
		.head     (head)
	);

	dtsp_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.pop     (pop),
		.results (results)
	);

endmodule

/* design/dtsp_front.sv */
// Front end: accepts characters and classifies them into tokens for the queue.
// Depends on dtsp_pkg and dtsp_char_if.
module dtsp_front (
	dtsp_char_if.sink              chars,
	input  logic                   q_full,
	output logic                   push,
	output dtsp_pkg::dtsp_token_t  tok
);

	logic is_digit;

	assign is_digit     = (chars.char_code >= dtsp_pkg::CH_ZERO) &&
		(chars.char_code <= dtsp_pkg::CH_NINE);
	assign chars.ready = !q_full;
	assign push        = chars.valid && !q_full;

	always_comb begin
		tok.digit = 4'(chars.char_code - dtsp_pkg::CH_ZERO);
		if (chars.char_code == dtsp_pkg::CH_NUL) begin
			tok.kind = dtsp_pkg::TOK_END;
		end else if (is_digit) begin
			tok.kind = dtsp_pkg::TOK_DIGIT;
		end else if (chars.char_code == dtsp_pkg::CH_MINUS) begin
			tok.kind = dtsp_pkg::TOK_MINUS;
		end else begin
			tok.kind = dtsp_pkg::TOK_SEP;
		end
	end

endmodule

/* design/dtsp_queue.sv */
// Small token queue between front and back ends.
// Depends on dtsp_pkg.
module dtsp_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  dtsp_pkg::dtsp_token_t  push_tok,
	input  logic                   pop,
	output logic                   full,
	output dtsp_pkg::dtsp_qhead_t  head
);

	dtsp_pkg::dtsp_token_t          mem_q [dtsp_pkg::QDEPTH];
	logic [dtsp_pkg::QAW-1:0]       wr_ptr_q;
	logic [dtsp_pkg::QAW-1:0]       rd_ptr_q;
	logic [dtsp_pkg::QCW-1:0]       count_q;
	logic                           do_push;
	logic                           do_pop;

	assign full       = (count_q == dtsp_pkg::QCW'(dtsp_pkg::QDEPTH));
	assign head.valid = (count_q != '0);
	assign head.tok   = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head.valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_tok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* design/dtsp_back.sv */
// Back end: runs the accumulator and field store on queued tokens, holds the result register.
// Depends on dtsp_pkg and dtsp_result_if.
module dtsp_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  dtsp_pkg::dtsp_qhead_t  head,
	output logic                   pop,
	dtsp_result_if.source          results
);

	logic [dtsp_pkg::ACC_W-1:0]    acc_q;
	logic [dtsp_pkg::IDX_W-1:0]    idx_q;
	logic                          at_start_q;
	logic                          fut_q;
	logic [dtsp_pkg::FIELD_W-1:0]  fields_q [dtsp_pkg::FIELD_COUNT];

	logic [dtsp_pkg::ACC_W-1:0]    cur_acc;
	logic [dtsp_pkg::IDX_W-1:0]    cur_idx;
	logic                          cur_fut;
	logic                          pend_ok;
	logic                          room;
	logic                          is_end;
	logic                          store_en;
	logic [dtsp_pkg::ACC_W-1:0]    year_adj;
	logic [dtsp_pkg::ACC_W-1:0]    acc_base;
	logic [dtsp_pkg::ACC_W-1:0]    dig_acc;

	logic [dtsp_pkg::ACC_W-1:0]    acc_n;
	logic [dtsp_pkg::IDX_W-1:0]    idx_n;
	logic [dtsp_pkg::FIELD_W-1:0]  fields_n [dtsp_pkg::FIELD_COUNT];
	dtsp_pkg::dtsp_status_t        status_n;

	logic                          res_valid_q;
	logic [dtsp_pkg::STATUS_W-1:0] res_status_q;
	logic [dtsp_pkg::FIELD_W-1:0]  res_fields_q [dtsp_pkg::FIELD_COUNT];
	logic [dtsp_pkg::IDX_W-1:0]    res_found_q;

	assign is_end = (head.tok.kind == dtsp_pkg::TOK_END);
	assign pop    = head.valid && (!is_end || !res_valid_q || results.ready);

	// string start clears the working state before the token is applied
	always_comb begin
		cur_acc  = at_start_q ? dtsp_pkg::NO_VALUE : acc_q;
		cur_idx  = at_start_q ? '0 : idx_q;
		cur_fut  = at_start_q ? (head.tok.kind == dtsp_pkg::TOK_MINUS) : fut_q;
		room     = (cur_idx < dtsp_pkg::IDX_W'(dtsp_pkg::FIELD_COUNT));
		pend_ok  = (cur_acc != dtsp_pkg::NO_VALUE) && room;
		year_adj = ((cur_idx == '0) && (cur_acc >= dtsp_pkg::YEAR_BASE)) ?
			(cur_acc - dtsp_pkg::YEAR_BASE) : cur_acc;
		acc_base = (cur_acc == dtsp_pkg::NO_VALUE) ? '0 : cur_acc;
		dig_acc  = (acc_base << 3) + (acc_base << 1) +
			dtsp_pkg::ACC_W'(head.tok.digit);
	end

	always_comb begin
		store_en = 1'b0;
		acc_n    = cur_acc;
		case (head.tok.kind)
			dtsp_pkg::TOK_END: begin
				store_en = !cur_fut && pend_ok;
				acc_n    = dtsp_pkg::NO_VALUE;
			end
			dtsp_pkg::TOK_DIGIT: begin
				if (!cur_fut && room) begin
					acc_n = dig_acc;
				end
			end
			default: begin
				if (!cur_fut && pend_ok) begin
					store_en = 1'b1;
					acc_n    = dtsp_pkg::NO_VALUE;
				end
			end
		endcase
		idx_n = store_en ? (cur_idx + 1'b1) : cur_idx;
		for (int k = 0; k < dtsp_pkg::FIELD_COUNT; k++) begin
			if (store_en && (cur_idx == dtsp_pkg::IDX_W'(k))) begin
				fields_n[k] = year_adj[dtsp_pkg::FIELD_W-1:0];
			end else begin
				fields_n[k] = at_start_q ? '0 : fields_q[k];
			end
		end
		if (cur_fut) begin
			status_n = dtsp_pkg::ST_FUTURE;
		end else if (idx_n >= dtsp_pkg::IDX_W'(dtsp_pkg::FIELD_COUNT)) begin
			status_n = dtsp_pkg::ST_FULL;
		end else begin
			status_n = dtsp_pkg::ST_PAST;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= dtsp_pkg::NO_VALUE;
			idx_q       <= '0;
			at_start_q  <= 1'b1;
			fut_q       <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				acc_q      <= acc_n;
				idx_q      <= idx_n;
				at_start_q <= is_end;
				fut_q      <= cur_fut;
			end
			if (pop && is_end) begin
				res_valid_q <= 1'b1;
			end else if (results.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			fields_q <= fields_n;
		end
		if (pop && is_end) begin
			res_status_q <= status_n;
			res_found_q  <= cur_fut ? '0 : idx_n;
			for (int k = 0; k < dtsp_pkg::FIELD_COUNT; k++) begin
				res_fields_q[k] <= cur_fut ? '0 : fields_n[k];
			end
		end
	end

	assign results.valid        = res_valid_q;
	assign results.status       = res_status_q;
	assign results.year         = res_fields_q[0];
	assign results.month        = res_fields_q[1];
	assign results.day          = res_fields_q[2];
	assign results.hours        = res_fields_q[3];
	assign results.minutes      = res_fields_q[4];
	assign results.seconds      = res_fields_q[5];
	assign results.fields_found = res_found_q;

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= dtsp_pkg::IDX_W'(dtsp_pkg::FIELD_COUNT))
		else $error("field index beyond six");

	a_end_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		pop && is_end |=> at_start_q && res_valid_q)
		else $error("terminator did not restart the string or raise a result");

	a_future_empty: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && (res_status_q == dtsp_pkg::ST_FUTURE) |-> (res_found_q == '0))
		else $error("future result carries fields");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && (res_status_q == dtsp_pkg::ST_FULL) |->
		(res_found_q == dtsp_pkg::IDX_W'(dtsp_pkg::FIELD_COUNT)))
		else $error("full status without six fields");

	a_future_no_store: assert property (@(posedge clk) disable iff (!arst_n)
		fut_q && !at_start_q |-> (idx_q == '0))
		else $error("field stored after leading minus");

endmodule

/* dv/testbench.sv */
// Testbench for datetime_string_parser: sends text one character per request, predicts each
// parsed-string result and checks it field by field, with random idling on both channels.
// Depends on dtsp_pkg, dtsp_char_if, dtsp_result_if and the datetime_string_parser RTL.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import dtsp_pkg::*;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [FIELD_W-1:0]  year;
		logic [FIELD_W-1:0]  month;
		logic [FIELD_W-1:0]  day;
		logic [FIELD_W-1:0]  hours;
		logic [FIELD_W-1:0]  minutes;
		logic [FIELD_W-1:0]  seconds;
		logic [IDX_W-1:0]    fields_found;
	} parse_result_t;

	class parse_checker;
		logic [ACC_W-1:0]   acc;
		logic [IDX_W-1:0]   idx;
		bit                 at_start;
		bit                 future;
		logic [FIELD_W-1:0] fields [FIELD_COUNT];
		parse_result_t      pending_results [$];
		int unsigned        errors;

		function new();
			acc = NO_VALUE;
			idx = '0;
			at_start = 1'b1;
			future = 1'b0;
			errors = 0;
			foreach (fields[k]) fields[k] = '0;
		endfunction

		task report(string msg);
			$display("%t  mismatch: %s", $realtime, msg);
			errors++;
		endtask

		function void store_field();
			logic [ACC_W-1:0] v;
			if (acc != NO_VALUE && idx < FIELD_COUNT) begin
				v = acc;
				if (idx == 0 && v >= YEAR_BASE) v = v - YEAR_BASE;
				fields[idx] = v[FIELD_W-1:0];
				idx++;
				acc = NO_VALUE;
			end
		endfunction

		function void predict_char(logic [CHAR_W-1:0] c);
			parse_result_t r;
			if (at_start) begin
				foreach (fields[k]) fields[k] = '0;
				idx = '0;
				acc = NO_VALUE;
				future = (c == CH_MINUS);
				at_start = 1'b0;
			end
			if (c == CH_NUL) begin
				if (!future) store_field();
				r = '0;
				if (future) begin
					r.status = ST_FUTURE;
				end else begin
					r.status = (idx >= FIELD_COUNT) ? ST_FULL : ST_PAST;
					r.year = fields[0];
					r.month = fields[1];
					r.day = fields[2];
					r.hours = fields[3];
					r.minutes = fields[4];
					r.seconds = fields[5];
					r.fields_found = idx;
				end
				pending_results.push_back(r);
				at_start = 1'b1;
				acc = NO_VALUE;
			end else if (!future && idx < FIELD_COUNT) begin
				if (c >= CH_ZERO && c <= CH_NINE)
					acc = ((acc == NO_VALUE) ? ACC_W'(0) : acc) * ACC_W'(10)
						+ ACC_W'(c - CH_ZERO);
				else
					store_field();
			end
		endfunction

		task field_check(string name, logic [FIELD_W-1:0] got, logic [FIELD_W-1:0] want);
			if (got !== want)
				report($sformatf("%s got %0d, expected %0d", name, got, want));
		endtask

		task check_result(parse_result_t got);
			parse_result_t want;
			if (pending_results.size() == 0) begin
				report("result with no terminated string waiting");
			end else begin
				want = pending_results.pop_front();
				field_check("status", FIELD_W'(got.status), FIELD_W'(want.status));
				field_check("year", got.year, want.year);
				field_check("month", got.month, want.month);
				field_check("day", got.day, want.day);
				field_check("hours", got.hours, want.hours);
				field_check("minutes", got.minutes, want.minutes);
				field_check("seconds", got.seconds, want.seconds);
				field_check("fields_found", FIELD_W'(got.fields_found),
					FIELD_W'(want.fields_found));
			end
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	bit   calm = 1'b0;
	logic [CHAR_W-1:0] text [$];
	parse_checker tracker = new();

	dtsp_char_if   chars_bus ();
	dtsp_result_if results_bus ();

	datetime_string_parser dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.chars   (chars_bus),
		.results (results_bus)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (chars_bus.valid && chars_bus.ready)
				tracker.predict_char(chars_bus.char_code);
			if (results_bus.valid && results_bus.ready)
				tracker.check_result('{status: results_bus.status, year: results_bus.year,
					month: results_bus.month, day: results_bus.day,
					hours: results_bus.hours, minutes: results_bus.minutes,
					seconds: results_bus.seconds, fields_found: results_bus.fields_found});
		end
	end

	function automatic void append_text(string s);
		foreach (s[i]) text.push_back(s[i]);
	endfunction

	function automatic void add_num(int unsigned v);
		append_text(($urandom_range(0, 4) == 0) ? $sformatf("%03d", v) : $sformatf("%0d", v));
	endfunction

	function automatic void add_sep();
		logic [CHAR_W-1:0] c;
		case ($urandom_range(0, 7))
			0: c = "-";
			1: c = "/";
			2: c = ":";
			3: c = " ";
			4: c = "T";
			5: c = ".";
			default: begin
				do c = CHAR_W'($urandom_range(1, 255)); while (c >= CH_ZERO && c <= CH_NINE);
			end
		endcase
		text.push_back(c);
	endfunction

	function automatic logic [CHAR_W-1:0] any_char();
		return ($urandom_range(0, 1) == 0) ? CHAR_W'(CH_ZERO + $urandom_range(0, 9))
			: CHAR_W'($urandom_range(1, 255));
	endfunction

	task automatic send_char(input logic [CHAR_W-1:0] c);
		int unsigned gap;
		gap = calm ? 0 : $urandom_range(0, 13);
		if (gap != 0) begin
			chars_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		chars_bus.valid <= 1'b1;
		chars_bus.char_code <= c;
		do @(posedge clk); while (!chars_bus.ready);
	endtask

	task automatic send_text();
		text.push_back(CH_NUL);
		foreach (text[i]) send_char(text[i]);
		text.delete();
	endtask

	task automatic wait_idle();
		chars_bus.valid <= 1'b0;
		do @(posedge clk); while (tracker.pending_results.size() != 0);
	endtask

	initial begin
		int unsigned stall;
		results_bus.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = calm ? 0 : $urandom_range(0, 13);
			if (stall != 0) begin
				results_bus.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			results_bus.ready <= 1'b1;
			do @(posedge clk); while (!results_bus.valid);
		end
	end

	initial begin
		int unsigned sent, next_pause, kind, plan, n, k;
		chars_bus.valid = 1'b0;
		chars_bus.char_code = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty string, leading minus, run equal to no-value, six fields then ignored tail
		send_text();
		append_text("-9");
		send_text();
		append_text("65535");
		send_text();
		append_text("2255");
		text.push_back(8'hFF);
		append_text("9:0/1 2 3 4");
		send_text();
		wait_idle();

		sent = 0;
		next_pause = 250;
		while (sent < 2000) begin
			calm = ($urandom_range(0, 7) == 0);
			kind = $urandom_range(0, 99);
			if (kind < 60) begin
				plan = ($urandom_range(0, 3) != 0) ? FIELD_COUNT : $urandom_range(1, 8);
				for (k = 0; k < plan; k++) begin
					if (k != 0) begin
						add_sep();
						if ($urandom_range(0, 15) == 0) add_sep();
					end
					if (k == 0) begin
						case ($urandom_range(0, 3))
							0: add_num(2000 + $urandom_range(0, 300));
							1: add_num($urandom_range(1990, 2010));
							2: add_num($urandom_range(0, 99));
							default: add_num($urandom_range(0, 65535));
						endcase
					end else begin
						add_num(($urandom_range(0, 7) == 0) ? $urandom_range(0, 999)
							: $urandom_range(0, 59));
					end
				end
				if ($urandom_range(0, 3) == 0) begin
					add_sep();
					add_num($urandom_range(0, 999));
				end
				sent += text.size() + 1;
			end else if (kind < 70) begin
				text.push_back(CH_MINUS);
				repeat ($urandom_range(0, 6)) text.push_back(any_char());
				sent += text.size() + 1;
			end else if (kind < 80) begin
				n = $urandom_range(5, 9);
				repeat (n) text.push_back(CHAR_W'(CH_ZERO + $urandom_range(0, 9)));
				if ($urandom_range(0, 1) == 0) begin
					add_sep();
					add_num($urandom_range(0, 65535));
				end
				sent += text.size() + 1;
			end else begin
				n = $urandom_range(0, 12);
				repeat (n) text.push_back(any_char());
				sent += n + 1;
			end
			send_text();
			if (sent >= next_pause) begin
				wait_idle();
				next_pause += 250;
			end
		end

		calm = 1'b0;
		wait_idle();
		repeat (8) @(posedge clk);
		if (tracker.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#5ms;
		$display("DONE: errors detected");
		$finish;
	end
endmodule

/* datetime_string_parser.f */
design/dtsp_pkg.sv
design/dtsp_char_if.sv
design/dtsp_result_if.sv
design/dtsp_front.sv
design/dtsp_queue.sv
design/dtsp_back.sv
design/datetime_string_parser.sv
dv/testbench.sv
